### hw/rtl/ppe_pkg.sv
// shared constants for the posit pack encoder
`timescale 1ns / 1ps

package ppe_pkg;

   localparam int WORD_W     = 32;
   localparam int EXP_W      = 12;
   localparam int FRAC_W     = 32;
   localparam int SIZE_W     = 6;
   localparam int ES_W       = 3;
   localparam int INT_EXP_W  = 14;
   localparam int REQ_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select is address bit 2
   localparam logic REG_POSIT_SIZE = 1'b0;
   localparam logic REG_EXP_SIZE   = 1'b1;

   localparam logic [SIZE_W-1:0] POSIT_SIZE_RESET = 6'd32;
   localparam logic [ES_W-1:0]   EXP_SIZE_RESET   = 3'd2;
   localparam logic [SIZE_W-1:0] POSIT_SIZE_MIN   = 6'd2;
   localparam logic [SIZE_W-1:0] POSIT_SIZE_MAX   = 6'd32;

endpackage

### hw/rtl/posit_pack_encoder.sv
// posit pack encoder: unpacked sign/exponent/fraction to left-aligned posit
// an accepted transaction passes the input register, then the result register, before rsp_tvalid rises
// throughput: one transaction per cycle while rsp_tready is high, set by the input and result registers
// the input register frees whenever the result register moves on or is empty
// reset (synchronous, active high) empties both stages; posit_size 32, exp_size 2
`timescale 1ns / 1ps

module posit_pack_encoder (
   input  logic                                clock,
   input  logic                                reset,
   // [0] negative, [12:1] exponent, [44:13] fraction, [47:45] zero
   input  logic [ppe_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] posit_word
   output logic [ppe_pkg::WORD_W-1:0]          rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppe_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ppe_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int WW = ppe_pkg::WORD_W;
   localparam int XW = ppe_pkg::INT_EXP_W;

   // configuration registers
   logic [ppe_pkg::SIZE_W-1:0] posit_size_ff, posit_size_in;
   logic [ppe_pkg::ES_W-1:0]   exp_size_ff, exp_size_in;
   logic                       csr_write;

   // pipeline registers
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_neg_ff;
   logic [ppe_pkg::EXP_W-1:0]   s1_exp_ff;
   logic [ppe_pkg::FRAC_W-1:0]  s1_frac_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]               rsp_data_ff, rsp_data_in;
   logic                        s1_load, rsp_load;

   // encode datapath
   logic [ppe_pkg::SIZE_W-1:0]  nbits;
   logic [ppe_pkg::ES_W-1:0]    es;
   logic [11:0]                 maxexp;
   logic signed [XW-1:0]        maxexp_s, e_in, e_c, e_b1, e_f;
   logic signed [XW-1:0]        reg0, reg1, reg_f, neg_reg;
   logic [XW-1:0]               rs0, rs_f;
   logic                        bump;
   logic [6:0]                  rem;
   logic [WW-1:0]               regbits, expbits, body, shifted, packed_w, keep, result;

   function automatic logic [XW-1:0] regime_len(input logic signed [XW-1:0] r);
      logic [XW-1:0] len;
      if (r[XW-1]) begin
         len = XW'(-r) + XW'(1);
      end else begin
         len = XW'(r) + XW'(2);
      end
      return len;
   endfunction

   // apb register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      posit_size_in = posit_size_ff;
      exp_size_in   = exp_size_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            ppe_pkg::REG_POSIT_SIZE: posit_size_in = csr_pwdata[ppe_pkg::SIZE_W-1:0];
            ppe_pkg::REG_EXP_SIZE:   exp_size_in   = csr_pwdata[ppe_pkg::ES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         ppe_pkg::REG_POSIT_SIZE:
            csr_prdata = {{(ppe_pkg::CSR_DATA_W-ppe_pkg::SIZE_W){1'b0}}, posit_size_ff};
         ppe_pkg::REG_EXP_SIZE:
            csr_prdata = {{(ppe_pkg::CSR_DATA_W-ppe_pkg::ES_W){1'b0}}, exp_size_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         posit_size_ff <= ppe_pkg::POSIT_SIZE_RESET;
         exp_size_ff   <= ppe_pkg::EXP_SIZE_RESET;
      end else begin
         posit_size_ff <= posit_size_in;
         exp_size_ff   <= exp_size_in;
      end
   end

   // handshake: each stage loads when empty or when the one after it moves
   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign s1_load      = !s1_valid_ff || rsp_load;
   assign req_tready   = s1_load;
   assign s1_valid_in  = s1_load ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_tvalid) begin
         s1_neg_ff  <= req_tdata[0];
         s1_exp_ff  <= req_tdata[ppe_pkg::EXP_W:1];
         s1_frac_ff <= req_tdata[ppe_pkg::EXP_W+ppe_pkg::FRAC_W:ppe_pkg::EXP_W+1];
      end
      if (rsp_load && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // encode
   always_comb begin
      if (posit_size_ff < ppe_pkg::POSIT_SIZE_MIN) begin
         nbits = ppe_pkg::POSIT_SIZE_MIN;
      end else if (posit_size_ff > ppe_pkg::POSIT_SIZE_MAX) begin
         nbits = ppe_pkg::POSIT_SIZE_MAX;
      end else begin
         nbits = posit_size_ff;
      end
      es = exp_size_ff;

      // saturate the exponent to +/- 2^es * (nbits - 2)
      maxexp   = {7'd0, 5'(nbits - 6'd2)} << es;
      maxexp_s = {2'b00, maxexp};
      e_in     = {{(XW-ppe_pkg::EXP_W){s1_exp_ff[ppe_pkg::EXP_W-1]}}, s1_exp_ff};
      if (e_in > maxexp_s) begin
         e_c = maxexp_s;
      end else if (e_in < -maxexp_s) begin
         e_c = -maxexp_s;
      end else begin
         e_c = e_in;
      end

      // regime for the plain and the bumped exponent side by side
      e_b1 = e_c + XW'(1);
      reg0 = e_c >>> es;
      reg1 = e_b1 >>> es;
      rs0  = regime_len(reg0);
      bump = ({1'b0, rs0} + (XW+1)'(1) + (XW+1)'(es) >= (XW+1)'(nbits))
             && s1_frac_ff[ppe_pkg::FRAC_W-1];
      e_f   = bump ? e_b1 : e_c;
      reg_f = bump ? reg1 : reg0;
      rs_f  = regime_len(reg_f);
      rem   = e_f[6:0] & ~(7'h7f << es);

      // run of ones ended by a zero, or zeros ended by a one
      neg_reg = -reg_f;
      if (reg_f[XW-1]) begin
         if (neg_reg >= XW'(WW)) begin
            regbits = '0;
         end else begin
            regbits = {1'b1, {(WW-1){1'b0}}} >> neg_reg[4:0];
         end
      end else if (reg_f >= XW'(WW-1)) begin
         regbits = '1;
      end else begin
         regbits = ~({WW{1'b1}} >> ({1'b0, reg_f[4:0]} + 6'd1));
      end

      expbits = {rem, {(WW-7){1'b0}}} << (3'd7 - es);
      body    = expbits | (s1_frac_ff >> es);
      if (rs_f >= XW'(WW)) begin
         shifted = '0;
      end else begin
         shifted = body >> rs_f[4:0];
      end
      packed_w = (regbits | shifted) >> 1;

      keep   = ~({WW{1'b1}} >> nbits);
      result = packed_w & keep;
      if (s1_neg_ff) begin
         result = (WW'(0) - result) & keep;
      end
      rsp_data_in = result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // assertions
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted transaction did not reach the input stage");

   a_stage_moves_to_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_load) |=> rsp_valid_ff)
      else $error("input stage advanced without a result");

   a_stalled_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_load) |=> (s1_valid_ff && $stable(s1_frac_ff)
                                      && $stable(s1_exp_ff)))
      else $error("stalled input stage lost its transaction");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
